// ----- rtl/core/sidsrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidsrd_pkg: shared types and codes for the sorted identifier set
// Field widths, opcodes, result status codes and the compare result bundle.
// ----------------------------------------------------------------------------
package sidsrd_pkg;

	localparam int ID_W    = 32;
	localparam int ST_W    = 3;
	localparam int CNTO_W  = 6;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [ST_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
	localparam logic [ST_W-1:0] ST_REMOVED = 3'd3;
	localparam logic [ST_W-1:0] ST_NONE    = 3'd4;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/sidsrd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidsrd_if: command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sidsrd_in_if;
	import sidsrd_pkg::*;

	logic            valid;
	logic            ready;
	logic            opcode;
	logic [ID_W-1:0] ident;
	logic [ID_W-1:0] range_high;

	modport source (output valid, output opcode, output ident, output range_high,
		input ready);
	modport sink (input valid, input opcode, input ident, input range_high,
		output ready);
endinterface

interface sidsrd_out_if;
	import sidsrd_pkg::*;

	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   removed_ident;
	logic [ST_W-1:0]   status;
	logic              last;
	logic [CNTO_W-1:0] entries_after;

	modport source (output valid, output removed_ident, output status, output last,
		output entries_after, input ready);
	modport sink (input valid, input removed_ident, input status, input last,
		input entries_after, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sidsrd_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidsrd_store: identifier memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sidsrd_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [sidsrd_pkg::ID_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [sidsrd_pkg::ID_W-1:0] rdata
);
	import sidsrd_pkg::*;

	logic [ID_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/core/sidsrd_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sidsrd_cmp: shared identifier comparator
// Unsigned less-than and equal of two identifiers.
// ----------------------------------------------------------------------------
module sidsrd_cmp (
	input  logic [sidsrd_pkg::ID_W-1:0] a,
	input  logic [sidsrd_pkg::ID_W-1:0] b,
	output sidsrd_pkg::cmp_res_t        res
);
	import sidsrd_pkg::*;

	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule
`default_nettype wire

// ----- rtl/core/sorted_id_set_range_delete.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_id_set_range_delete: sorted identifier set with range delete
// Ascending set of up to CAPACITY identifiers; add with dedup, range removal
// with one result beat per removed identifier.
// ----------------------------------------------------------------------------
// The set lives in a single-port-read memory and is walked one entry at a time
// by a small sequencer feeding one shared 32-bit comparator. The block takes
// one command at a time (cmd.ready only when idle). An add searches for the
// insert position and moves the entries from there to the top up by one, each
// entry read through the registered memory read in front of the comparator. A
// remove reads every entry once: entries past the range are copied down in the
// same pass, and removed identifiers stream out as they are found. Result
// beats sit in an output register, so a stalled sink only holds the scan when
// a second removed identifier is ready to go out.
// ----------------------------------------------------------------------------
module sorted_id_set_range_delete #(
	parameter int CAPACITY = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	sidsrd_in_if.sink    cmd,
	sidsrd_out_if.source res
);
	import sidsrd_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [14:0] {
		S_IDLE       = 15'b000000000000001,
		S_A_RD       = 15'b000000000000010,
		S_A_CMP      = 15'b000000000000100,
		S_A_DEC      = 15'b000000000001000,
		S_A_SH_RD    = 15'b000000000010000,
		S_A_SH_WR    = 15'b000000000100000,
		S_R_CHK      = 15'b000000001000000,
		S_R_SKIP_RD  = 15'b000000010000000,
		S_R_SKIP_CMP = 15'b000000100000000,
		S_R_TAKE_RD  = 15'b000001000000000,
		S_R_TAKE_CMP = 15'b000010000000000,
		S_R_MOVE_RD  = 15'b000100000000000,
		S_R_MOVE_WR  = 15'b001000000000000,
		S_R_END      = 15'b010000000000000,
		S_FIN        = 15'b100000000000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;     // stored entries
	logic [CW-1:0]   left_q;    // entries left as seen by the result stream
	logic [CW-1:0]   idx_q;     // scan index
	logic [CW-1:0]   pos_q;     // insert position
	logic [CW-1:0]   wp_q;      // compaction write pointer
	logic [ID_W-1:0] key_q;
	logic [ID_W-1:0] hi_q;
	logic [ST_W-1:0] st_q;
	logic            pend_v_q;  // a removed identifier waits for its last mark
	logic [ID_W-1:0] pend_q;

	logic              ov_q;
	logic [ID_W-1:0]   o_ident_q;
	logic [ST_W-1:0]   o_status_q;
	logic              o_last_q;
	logic [CNTO_W-1:0] o_cnt_q;

	// memory and comparator hookup
	logic            we;
	logic [AW-1:0]   waddr;
	logic [ID_W-1:0] wdata;
	logic [AW-1:0]   raddr;
	logic [ID_W-1:0] rdata;
	logic [ID_W-1:0] cmp_a;
	logic [ID_W-1:0] cmp_b;
	cmp_res_t        cres;
	logic [CW-1:0]   idx_m1;

	// result beat loading
	logic            can_emit;
	logic            em_fire;
	logic [ID_W-1:0] em_ident;
	logic [ST_W-1:0] em_status;
	logic            em_last;
	logic [CW-1:0]   em_cnt;

	sidsrd_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	sidsrd_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cres)
	);

	assign idx_m1   = idx_q - 1'b1;
	assign can_emit = !ov_q || res.ready;

	// range check compares high against low; the take phase compares against
	// high; everything else compares the stored entry against the key
	always_comb begin
		cmp_a = (state_q == S_R_CHK) ? hi_q : rdata;
		cmp_b = (state_q == S_R_TAKE_CMP) ? hi_q : key_q;
		// shift-up reads the entry below the one being written
		raddr = (state_q == S_A_SH_RD) ? idx_m1[AW-1:0] : idx_q[AW-1:0];
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_A_SH_RD: begin
				if (idx_q == pos_q) begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = key_q;
				end
			end
			S_A_SH_WR: begin
				we = 1'b1;
			end
			S_R_MOVE_WR: begin
				we    = 1'b1;
				waddr = wp_q[AW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		em_fire   = 1'b0;
		em_ident  = pend_q;
		em_status = ST_REMOVED;
		em_last   = 1'b0;
		em_cnt    = left_q - 1'b1;
		case (state_q)
			S_R_TAKE_CMP: begin
				// a further identifier in range: the pending one is not last
				em_fire = cres.lt && pend_v_q && can_emit;
			end
			S_R_END: begin
				em_fire = pend_v_q && can_emit;
				em_last = 1'b1;
			end
			S_FIN: begin
				em_fire   = can_emit;
				em_ident  = '0;
				em_status = st_q;
				em_last   = 1'b1;
				em_cnt    = cnt_q;
			end
			default: begin
				em_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			left_q     <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			wp_q       <= '0;
			key_q      <= '0;
			hi_q       <= '0;
			st_q       <= ST_NONE;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
			ov_q       <= 1'b0;
			o_ident_q  <= '0;
			o_status_q <= ST_NONE;
			o_last_q   <= 1'b0;
			o_cnt_q    <= '0;
		end else begin
			if (em_fire) begin
				ov_q       <= 1'b1;
				o_ident_q  <= em_ident;
				o_status_q <= em_status;
				o_last_q   <= em_last;
				o_cnt_q    <= CNTO_W'(em_cnt);
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						key_q   <= cmd.ident;
						hi_q    <= cmd.range_high;
						idx_q   <= '0;
						state_q <= (cmd.opcode == OP_ADD) ? S_A_RD : S_R_CHK;
					end
				end
				// search for the first entry not below the key
				S_A_RD: begin
					if (idx_q == cnt_q) begin
						pos_q   <= idx_q;
						state_q <= S_A_DEC;
					end else begin
						state_q <= S_A_CMP;
					end
				end
				S_A_CMP: begin
					if (cres.lt) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_A_RD;
					end else if (cres.eq) begin
						st_q    <= ST_PRESENT;
						state_q <= S_FIN;
					end else begin
						pos_q   <= idx_q;
						state_q <= S_A_DEC;
					end
				end
				S_A_DEC: begin
					if (cnt_q == CAP_C) begin
						st_q    <= ST_FULL;
						state_q <= S_FIN;
					end else begin
						idx_q   <= cnt_q;
						state_q <= S_A_SH_RD;
					end
				end
				// move entries up from the top down to the insert position
				S_A_SH_RD: begin
					if (idx_q == pos_q) begin
						cnt_q   <= cnt_q + 1'b1;
						st_q    <= ST_ADDED;
						state_q <= S_FIN;
					end else begin
						state_q <= S_A_SH_WR;
					end
				end
				S_A_SH_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_A_SH_RD;
				end
				S_R_CHK: begin
					pend_v_q <= 1'b0;
					left_q   <= cnt_q;
					if (cres.lt || cres.eq) begin
						st_q    <= ST_NONE;
						state_q <= S_FIN;
					end else begin
						state_q <= S_R_SKIP_RD;
					end
				end
				// skip entries below the range
				S_R_SKIP_RD: begin
					state_q <= (idx_q == cnt_q) ? S_R_END : S_R_SKIP_CMP;
				end
				S_R_SKIP_CMP: begin
					if (cres.lt) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_R_SKIP_RD;
					end else begin
						wp_q    <= idx_q;
						state_q <= S_R_TAKE_CMP;
					end
				end
				// collect entries inside the range
				S_R_TAKE_RD: begin
					state_q <= (idx_q == cnt_q) ? S_R_END : S_R_TAKE_CMP;
				end
				S_R_TAKE_CMP: begin
					if (cres.lt) begin
						if (!pend_v_q || can_emit) begin
							if (pend_v_q) begin
								left_q <= left_q - 1'b1;
							end
							pend_q   <= rdata;
							pend_v_q <= 1'b1;
							idx_q    <= idx_q + 1'b1;
							state_q  <= S_R_TAKE_RD;
						end
					end else begin
						state_q <= S_R_MOVE_WR;
					end
				end
				// copy entries above the range down over the hole
				S_R_MOVE_WR: begin
					wp_q    <= wp_q + 1'b1;
					idx_q   <= idx_q + 1'b1;
					state_q <= S_R_MOVE_RD;
				end
				S_R_MOVE_RD: begin
					state_q <= (idx_q == cnt_q) ? S_R_END : S_R_MOVE_WR;
				end
				S_R_END: begin
					if (!pend_v_q) begin
						st_q    <= ST_NONE;
						state_q <= S_FIN;
					end else if (can_emit) begin
						pend_v_q <= 1'b0;
						cnt_q    <= left_q - 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_FIN: begin
					if (can_emit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready         = (state_q == S_IDLE);
	assign res.valid         = ov_q;
	assign res.removed_ident = o_ident_q;
	assign res.status        = o_status_q;
	assign res.last          = o_last_q;
	assign res.entries_after = o_cnt_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("entry count above capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		em_fire |-> (!ov_q || res.ready))
		else $error("result register overwritten before taken");

	a_cnt_steady_on_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> $stable(cnt_q))
		else $error("entry count changed on command beat");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("removed identifier left pending at idle");

	a_not_last_is_removal: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !o_last_q) |-> (o_status_q == ST_REMOVED))
		else $error("non-final beat without removed status");
`endif

endmodule
`default_nettype wire
